@@ hdl/piter_pkg.sv @@
// ----------------------------------------------------------------------------
// piter_pkg
// Shared types, codes and helpers of the power iteration eigen solver.
// ----------------------------------------------------------------------------
package piter_pkg;

    localparam int MAX_SIZE_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W = 32;
    localparam int MAG_W  = 31;
    localparam int CNT_W  = 16;
    localparam int SIZE_W = 4;

    typedef enum logic [1:0] {
        CMD_LOAD_MATRIX = 2'd0,
        CMD_LOAD_VECTOR = 2'd1,
        CMD_START       = 2'd2,
        CMD_UNUSED      = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_ZERO      = 2'd2;

    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_TOL   = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // absolute value, clamped to the largest 31-bit magnitude
    function automatic logic [MAG_W-1:0] mag31(input logic signed [DATA_W:0] v);
        logic [DATA_W:0] a;
        a = v[DATA_W] ? (-v) : v;
        if (a > 33'h07fffffff) begin
            return 31'h7fffffff;
        end
        return a[MAG_W-1:0];
    endfunction

endpackage

@@ hdl/piter_mac.sv @@
// ----------------------------------------------------------------------------
// piter_mac
// Multiply-accumulate for one matrix row: product, floor shift, saturating sum.
// ----------------------------------------------------------------------------
module piter_mac #(
    parameter int FRACTION_BITS = piter_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  piter_pkg::mac_ctl_t in_ctl,
    input  logic signed [31:0]  a_data,
    input  logic signed [31:0]  x_data,
    output logic                out_valid,
    output logic signed [31:0]  out_sum
);
    import piter_pkg::*;

    mac_ctl_t           ctl1_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] acc_next;
    logic               out_valid_reg;

    logic signed [63:0] shifted;
    logic signed [31:0] term;
    logic signed [31:0] base;
    logic signed [32:0] sum;

    always_comb begin
        shifted = prod_reg >>> FRACTION_BITS;
        if (shifted > 64'sh000000007fffffff) begin
            term = 32'sh7fffffff;
        end else if (shifted < -64'sh0000000080000000) begin
            term = 32'sh80000000;
        end else begin
            term = shifted[31:0];
        end
        base = ctl1_reg.first ? 32'sd0 : acc_reg;
        sum  = {base[31], base} + {term[31], term};
        if (sum[32] != sum[31]) begin
            acc_next = sum[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            acc_next = sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            ctl1_reg      <= in_ctl;
            out_valid_reg <= ctl1_reg.valid && ctl1_reg.last;
        end
        if (in_ctl.valid) begin
            prod_reg <= 64'(a_data) * 64'(x_data);
        end
        if (ctl1_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = acc_reg;

endmodule

@@ hdl/piter_div.sv @@
// ----------------------------------------------------------------------------
// piter_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module piter_div #(
    parameter int NW = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [30:0]   den,
    output logic          done,
    output logic [NW-1:0] quot
);
    import piter_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [31:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [31:0]   shift_rem;
    logic          fits;

    always_comb begin
        shift_rem = {rem_reg[30:0], quo_reg[NW-1]};
        fits      = shift_rem >= {1'b0, den};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
        end else if (busy_reg) begin
            rem_reg <= fits ? (shift_rem - {1'b0, den}) : shift_rem;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

@@ hdl/power_iteration_eigen.sv @@
// ----------------------------------------------------------------------------
// power_iteration_eigen
// Dominant eigenvalue by power iteration over a matrix held in block memory.
// ----------------------------------------------------------------------------
// Load words are accepted only while idle. Each iteration of a start runs a
// multiply-accumulate pass (one memory read of A and x per cycle), then one
// bit-serial division per element and a check (a zero z skips both); the
// run then emits n words. No new word is taken until the run ends. Reset
// (aresetn low, synchronous) clears control and the configuration registers
// to their defaults; the memories are not cleared and need no clearing pass.
module power_iteration_eigen #(
    parameter int MAX_SIZE      = piter_pkg::MAX_SIZE_DEF,
    parameter int FRACTION_BITS = piter_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row[2:0], col[5:3], value[37:6]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // index[2:0], vector_value[34:3],
                                   // eigen_magnitude[65:35], iterations[81:66]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import piter_pkg::*;

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
    localparam int NW = DATA_W + FRACTION_BITS;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MAC   = 13'b0000000000010,
        S_DRAIN = 13'b0000000000100,
        S_EVAL  = 13'b0000000001000,
        S_ZERO  = 13'b0000000010000,
        S_DRD   = 13'b0000000100000,
        S_DLD   = 13'b0000001000000,
        S_DIV   = 13'b0000010000000,
        S_WB    = 13'b0000100000000,
        S_CHECK = 13'b0001000000000,
        S_ORD   = 13'b0010000000000,
        S_OLD   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    // configuration
    logic [SIZE_W-1:0] size_reg;
    logic [MAG_W-1:0]  tol_reg;
    logic [CNT_W-1:0]  limit_reg;

    // control
    state_t            state_reg,  state_next;
    logic [IW-1:0]     i_reg,      i_next;
    logic [IW-1:0]     j_reg,      j_next;
    logic [IW-1:0]     k_reg,      k_next;
    logic [IW-1:0]     zi_reg,     zi_next;
    logic [MAG_W-1:0]  zmax_reg,   zmax_next;
    logic [MAG_W-1:0]  err_reg,    err_next;
    logic [CNT_W-1:0]  iter_reg,   iter_next;
    logic [1:0]        status_reg, status_next;
    mac_ctl_t          issue_reg,  issue_next;
    logic              m_valid_reg, m_valid_next;

    // payload
    logic              sign_reg,    sign_next;
    logic signed [31:0] xhold_reg,  xhold_next;
    logic signed [31:0] qsat_reg,   qsat_next;
    logic [2:0]        m_index_reg, m_index_next;
    logic signed [31:0] m_value_reg, m_value_next;
    logic              m_last_reg,  m_last_next;

    // memories
    logic signed [31:0] mat_mem [MAX_SIZE*MAX_SIZE];
    logic signed [31:0] xv_mem  [MAX_SIZE];
    logic signed [31:0] zv_mem  [MAX_SIZE];
    logic signed [31:0] mat_rdata_reg;
    logic signed [31:0] x_rdata_reg;
    logic signed [31:0] z_rdata_reg;

    logic               mat_we;
    logic [AW-1:0]      mat_waddr;
    logic [AW-1:0]      mat_raddr;
    logic               x_we;
    logic [IW-1:0]      x_waddr;
    logic signed [31:0] x_wdata;
    logic [IW-1:0]      x_raddr;

    // input word
    logic               s_fire;
    cmd_t               in_cmd;
    logic [2:0]         in_row;
    logic [2:0]         in_col;
    logic signed [31:0] in_value;

    logic [IW-1:0]      nm1;
    logic [CNT_W-1:0]   limit_eff;

    logic               mac_valid;
    logic signed [31:0] mac_sum;
    logic [MAG_W-1:0]   mac_mag;

    logic               div_start;
    logic               div_done;
    logic [NW-1:0]      div_quot;
    logic [31:0]        z_mag;
    logic [NW-1:0]      div_num;
    logic signed [31:0] q_sat;
    logic [MAG_W-1:0]   diff_mag;

    assign s_fire   = s_tvalid && s_tready;
    assign in_cmd   = cmd_t'(s_tuser);
    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[37:6];

    always_comb begin
        if (size_reg == '0) begin
            nm1 = '0;
        end else if (32'(size_reg) > MAX_SIZE) begin
            nm1 = IW'(MAX_SIZE - 1);
        end else begin
            nm1 = IW'(size_reg - 4'd1);
        end
        limit_eff = (limit_reg == '0) ? 16'd1 : limit_reg;
    end

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= 4'd8;
            tol_reg   <= 31'd66;
            limit_reg <= 16'd1000;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_SIZE:  size_reg  <= pwdata[SIZE_W-1:0];
                REG_TOL:   tol_reg   <= pwdata[MAG_W-1:0];
                REG_LIMIT: limit_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SIZE:  prdata = {28'd0, size_reg};
            REG_TOL:   prdata = {1'b0, tol_reg};
            REG_LIMIT: prdata = {16'd0, limit_reg};
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    assign mat_waddr = AW'(in_row) * AW'(MAX_SIZE) + AW'(in_col);
    assign mat_raddr = AW'(i_reg) * AW'(MAX_SIZE) + AW'(j_reg);
    assign x_raddr   = (state_reg == S_MAC) ? j_reg : k_reg;

    always_ff @(posedge aclk) begin
        if (mat_we) begin
            mat_mem[mat_waddr] <= in_value;
        end
        mat_rdata_reg <= mat_mem[mat_raddr];
    end

    always_ff @(posedge aclk) begin
        if (x_we) begin
            xv_mem[x_waddr] <= x_wdata;
        end
        x_rdata_reg <= xv_mem[x_raddr];
    end

    always_ff @(posedge aclk) begin
        if (mac_valid) begin
            zv_mem[zi_reg] <= mac_sum;
        end
        z_rdata_reg <= zv_mem[k_reg];
    end

    // ------------------------------------------------------------------
    // Arithmetic units
    // ------------------------------------------------------------------
    piter_mac #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (issue_reg),
        .a_data    (mat_rdata_reg),
        .x_data    (x_rdata_reg),
        .out_valid (mac_valid),
        .out_sum   (mac_sum)
    );

    assign mac_mag = mag31({mac_sum[31], mac_sum});
    assign z_mag   = z_rdata_reg[31] ? (-z_rdata_reg) : z_rdata_reg;
    assign div_num = {z_mag, {FRACTION_BITS{1'b0}}};

    piter_div #(
        .NW (NW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (zmax_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        if (sign_reg) begin
            if (div_quot > NW'(64'h80000000)) begin
                q_sat = 32'sh80000000;
            end else begin
                q_sat = -div_quot[31:0];
            end
        end else begin
            if (div_quot > NW'(64'h7fffffff)) begin
                q_sat = 32'sh7fffffff;
            end else begin
                q_sat = div_quot[31:0];
            end
        end
        diff_mag = mag31({xhold_reg[31], xhold_reg} - {qsat_reg[31], qsat_reg});
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        zi_next      = zi_reg;
        zmax_next    = zmax_reg;
        err_next     = err_reg;
        iter_next    = iter_reg;
        status_next  = status_reg;
        issue_next   = '0;
        m_valid_next = m_valid_reg;
        sign_next    = sign_reg;
        xhold_next   = xhold_reg;
        qsat_next    = qsat_reg;
        m_index_next = m_index_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        mat_we       = 1'b0;
        x_we         = 1'b0;
        x_waddr      = k_reg;
        x_wdata      = qsat_reg;
        div_start    = 1'b0;

        // collect finished rows of z = A*x
        if (mac_valid) begin
            zi_next = zi_reg + 1'b1;
            if (mac_mag > zmax_reg) begin
                zmax_next = mac_mag;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (in_cmd)
                        CMD_LOAD_MATRIX: begin
                            if (32'(in_row) < MAX_SIZE && 32'(in_col) < MAX_SIZE) begin
                                mat_we = 1'b1;
                            end
                        end
                        CMD_LOAD_VECTOR: begin
                            if (32'(in_row) < MAX_SIZE) begin
                                x_we    = 1'b1;
                                x_waddr = IW'(in_row);
                                x_wdata = in_value;
                            end
                        end
                        CMD_START: begin
                            i_next     = '0;
                            j_next     = '0;
                            zi_next    = '0;
                            zmax_next  = '0;
                            iter_next  = '0;
                            state_next = S_MAC;
                        end
                        default: ;
                    endcase
                end
            end
            S_MAC: begin
                issue_next.valid = 1'b1;
                issue_next.first = (j_reg == '0);
                issue_next.last  = (j_reg == nm1);
                if (j_reg == nm1) begin
                    j_next = '0;
                    if (i_reg == nm1) begin
                        state_next = S_DRAIN;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (mac_valid && zi_reg == nm1) begin
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                k_next   = '0;
                err_next = '0;
                state_next = (zmax_reg == '0) ? S_ZERO : S_DRD;
            end
            S_ZERO: begin
                x_we    = 1'b1;
                x_wdata = '0;
                if (k_reg == nm1) begin
                    k_next      = '0;
                    status_next = ST_ZERO;
                    state_next  = S_ORD;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRD: begin
                state_next = S_DLD;
            end
            S_DLD: begin
                div_start  = 1'b1;
                sign_next  = z_rdata_reg[31];
                xhold_next = x_rdata_reg;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    qsat_next  = q_sat;
                    state_next = S_WB;
                end
            end
            S_WB: begin
                x_we = 1'b1;
                if (diff_mag > err_reg) begin
                    err_next = diff_mag;
                end
                if (k_reg == nm1) begin
                    state_next = S_CHECK;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_DRD;
                end
            end
            S_CHECK: begin
                k_next = '0;
                if (err_reg <= tol_reg) begin
                    status_next = ST_CONVERGED;
                    state_next  = S_ORD;
                end else if (iter_reg >= limit_eff) begin
                    status_next = ST_LIMIT;
                    state_next  = S_ORD;
                end else begin
                    i_next     = '0;
                    j_next     = '0;
                    zi_next    = '0;
                    zmax_next  = '0;
                    state_next = S_MAC;
                end
            end
            S_ORD: begin
                state_next = S_OLD;
            end
            S_OLD: begin
                m_valid_next = 1'b1;
                m_index_next = 3'(k_reg);
                m_value_next = x_rdata_reg;
                m_last_next  = (k_reg == nm1);
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (k_reg == nm1) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            zi_reg      <= '0;
            zmax_reg    <= '0;
            err_reg     <= '0;
            iter_reg    <= '0;
            status_reg  <= ST_CONVERGED;
            issue_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            zi_reg      <= zi_next;
            zmax_reg    <= zmax_next;
            err_reg     <= err_next;
            iter_reg    <= iter_next;
            status_reg  <= status_next;
            issue_reg   <= issue_next;
            m_valid_reg <= m_valid_next;
        end
        sign_reg    <= sign_next;
        xhold_reg   <= xhold_next;
        qsat_reg    <= qsat_next;
        m_index_reg <= m_index_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, iter_reg, zmax_reg, m_value_reg, m_index_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = m_last_reg;

endmodule
